@@ rtl/multi_line_text_edit_buffer_unit_macros.svh @@
// Assertion macros shared by the line editor checker.
`ifndef MULTI_LINE_TEXT_EDIT_BUFFER_UNIT_MACROS_SVH
`define MULTI_LINE_TEXT_EDIT_BUFFER_UNIT_MACROS_SVH

// same-cycle implication
`define MLTEB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLTEB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mlteb_pkg.sv @@
// Types and constants of the line editor buffer.
`default_nettype none

package mlteb_pkg;

   localparam int W_KEY  = 8;
   localparam int W_LINE = 3;
   localparam int W_COL  = 5;
   localparam int W_CHAR = 7;
   localparam int W_CSR_IDX = 2;

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [W_KEY-1:0] KEY_PREFIX = 8'd224;
   localparam logic [W_KEY-1:0] KEY_LEFT   = 8'd75;
   localparam logic [W_KEY-1:0] KEY_RIGHT  = 8'd77;
   localparam logic [W_KEY-1:0] KEY_UP     = 8'd72;
   localparam logic [W_KEY-1:0] KEY_DOWN   = 8'd80;
   localparam logic [W_KEY-1:0] KEY_HOME   = 8'd71;
   localparam logic [W_KEY-1:0] KEY_END    = 8'd79;
   localparam logic [W_KEY-1:0] KEY_DEL    = 8'd83;
   localparam logic [W_KEY-1:0] KEY_ENTER  = 8'd13;
   localparam logic [W_KEY-1:0] KEY_BACK   = 8'd8;
   localparam logic [W_KEY-1:0] PRINT_LO   = 8'd32;
   localparam logic [W_KEY-1:0] PRINT_HI   = 8'd126;

   localparam logic [W_CSR_IDX-1:0] CSR_LOWEST_CHAR  = 2'd0;
   localparam logic [W_CSR_IDX-1:0] CSR_HIGHEST_CHAR = 2'd1;

   localparam logic [W_CHAR-1:0] LOWEST_CHAR_RST  = 7'd48;
   localparam logic [W_CHAR-1:0] HIGHEST_CHAR_RST = 7'd122;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_UP_WAIT,
      ST_DOWN_WAIT,
      ST_SHIFT_INS,
      ST_SHIFT_DEL,
      ST_PUT,
      ST_RESULT
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_READ,
      ACT_PREFIX,
      ACT_ENTER,
      ACT_LEFT,
      ACT_RIGHT,
      ACT_UP,
      ACT_DOWN,
      ACT_HOME,
      ACT_END,
      ACT_DELETE,
      ACT_BACK,
      ACT_INSERT
   } act_type;

   typedef struct packed {
      logic load;
      logic prefix_set;
      logic prefix_clr;
      logic done_set;
      logic col_dec;
      logic col_inc;
      logic col_zero;
      logic col_end;
      logic rd_issue;
      logic rd_capture;
      logic up_issue;
      logic down_issue;
      logic up_load;
      logic down_load;
      logic del_start;
      logic del_back;
      logic ins_start;
      logic shift_run;
      logic put_char;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      act_type act;
      logic    pfx_clr;
      logic    shift_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ rtl/mlteb_req_if.sv @@
// Input channel of the line editor: key bytes and read commands.
`default_nettype none

interface mlteb_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [mlteb_pkg::W_KEY-1:0]    key_byte;
   logic [mlteb_pkg::W_LINE-1:0]   read_line;
   logic [mlteb_pkg::W_COL-1:0]    read_col;

   modport source (output valid, cmd, key_byte, read_line, read_col, input ready);
   modport sink   (input valid, cmd, key_byte, read_line, read_col, output ready);
endinterface

`default_nettype wire

@@ rtl/mlteb_rsp_if.sv @@
// Result channel of the line editor.
`default_nettype none

interface mlteb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mlteb_pkg::W_KEY-1:0]    read_char;
   logic [mlteb_pkg::W_LINE-1:0]   cursor_line;
   logic [mlteb_pkg::W_COL-1:0]    cursor_col;
   logic [mlteb_pkg::W_COL-1:0]    current_length;
   logic                           finished;

   modport source (output valid, read_char, cursor_line, cursor_col, current_length,
                   finished, input ready);
   modport sink   (input valid, read_char, cursor_line, cursor_col, current_length,
                   finished, output ready);
endinterface

`default_nettype wire

@@ rtl/mlteb_csr_if.sv @@
// Register write channel of the line editor.
`default_nettype none

interface mlteb_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mlteb_pkg::W_CSR_IDX-1:0]   index;
   logic [mlteb_pkg::W_CHAR-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/mlteb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mlteb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/mlteb_ctrl.sv @@
// Sequencer of the line editor: decodes each beat and steps the datapath.
`default_nettype none

module mlteb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire mlteb_pkg::dp_stat_type stat,
   output mlteb_pkg::ctrl_cmd_type     cmd
);

   mlteb_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlteb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mlteb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mlteb_pkg::ST_DECODE;
            end
         end
         mlteb_pkg::ST_DECODE: begin
            cmd.prefix_clr = stat.pfx_clr;
            state_in       = mlteb_pkg::ST_RESULT;
            unique case (stat.act)
               mlteb_pkg::ACT_NONE: begin
               end
               mlteb_pkg::ACT_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in     = mlteb_pkg::ST_READ_WAIT;
               end
               mlteb_pkg::ACT_PREFIX: cmd.prefix_set = 1'b1;
               mlteb_pkg::ACT_ENTER:  cmd.done_set   = 1'b1;
               mlteb_pkg::ACT_LEFT:   cmd.col_dec    = 1'b1;
               mlteb_pkg::ACT_RIGHT:  cmd.col_inc    = 1'b1;
               mlteb_pkg::ACT_HOME:   cmd.col_zero   = 1'b1;
               mlteb_pkg::ACT_END:    cmd.col_end    = 1'b1;
               mlteb_pkg::ACT_UP: begin
                  cmd.up_issue = 1'b1;
                  state_in     = mlteb_pkg::ST_UP_WAIT;
               end
               mlteb_pkg::ACT_DOWN: begin
                  cmd.down_issue = 1'b1;
                  state_in       = mlteb_pkg::ST_DOWN_WAIT;
               end
               mlteb_pkg::ACT_DELETE: begin
                  cmd.del_start = 1'b1;
                  state_in      = mlteb_pkg::ST_SHIFT_DEL;
               end
               mlteb_pkg::ACT_BACK: begin
                  cmd.del_start = 1'b1;
                  cmd.del_back  = 1'b1;
                  state_in      = mlteb_pkg::ST_SHIFT_DEL;
               end
               mlteb_pkg::ACT_INSERT: begin
                  cmd.ins_start = 1'b1;
                  state_in      = mlteb_pkg::ST_SHIFT_INS;
               end
               default: begin
               end
            endcase
         end
         mlteb_pkg::ST_READ_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = mlteb_pkg::ST_RESULT;
         end
         mlteb_pkg::ST_UP_WAIT: begin
            cmd.up_load = 1'b1;
            state_in    = mlteb_pkg::ST_RESULT;
         end
         mlteb_pkg::ST_DOWN_WAIT: begin
            cmd.down_load = 1'b1;
            state_in      = mlteb_pkg::ST_RESULT;
         end
         mlteb_pkg::ST_SHIFT_INS: begin
            cmd.shift_run = 1'b1;
            if (!stat.shift_busy) begin
               state_in = mlteb_pkg::ST_PUT;
            end
         end
         mlteb_pkg::ST_SHIFT_DEL: begin
            cmd.shift_run = 1'b1;
            if (!stat.shift_busy) begin
               state_in = mlteb_pkg::ST_RESULT;
            end
         end
         mlteb_pkg::ST_PUT: begin
            cmd.put_char = 1'b1;
            state_in     = mlteb_pkg::ST_RESULT;
         end
         mlteb_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = mlteb_pkg::ST_IDLE;
            end
         end
         default: state_in = mlteb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/mlteb_dp.sv @@
// Datapath of the line editor: cursor, line lengths, text RAM and shifter.
`default_nettype none

module mlteb_dp #(
   parameter int LINES          = 6,
   parameter int CHARS_PER_LINE = 20
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mlteb_pkg::ctrl_cmd_type             cmd,
   output mlteb_pkg::dp_stat_type                   stat,
   input  wire logic                                req_cmd,
   input  wire logic [mlteb_pkg::W_KEY-1:0]         req_key_byte,
   input  wire logic [mlteb_pkg::W_LINE-1:0]        req_read_line,
   input  wire logic [mlteb_pkg::W_COL-1:0]         req_read_col,
   input  wire logic                                csr_we,
   input  wire logic [mlteb_pkg::W_CSR_IDX-1:0]     csr_index,
   input  wire logic [mlteb_pkg::W_CHAR-1:0]        csr_data,
   output logic      [mlteb_pkg::W_KEY-1:0]         rsp_read_char,
   output logic      [mlteb_pkg::W_LINE-1:0]        rsp_cursor_line,
   output logic      [mlteb_pkg::W_COL-1:0]         rsp_cursor_col,
   output logic      [mlteb_pkg::W_COL-1:0]         rsp_current_length,
   output logic                                     rsp_finished
);

   localparam int DEPTH = LINES * CHARS_PER_LINE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int CW    = $clog2(CHARS_PER_LINE + 1);
   localparam int CMPW  = (CW > mlteb_pkg::W_COL) ? CW : mlteb_pkg::W_COL;

   // current beat
   logic                            it_cmd_ff, it_cmd_in;
   logic [mlteb_pkg::W_KEY-1:0]     it_key_ff, it_key_in;
   logic [mlteb_pkg::W_LINE-1:0]    it_rl_ff, it_rl_in;
   logic [mlteb_pkg::W_COL-1:0]     it_rc_ff, it_rc_in;

   logic [mlteb_pkg::W_CHAR-1:0]    lo_ff, hi_ff;

   logic                            prefix_ff, prefix_in;
   logic                            done_ff, done_in;
   logic [RW-1:0]                   row_ff, row_in;
   logic [CW-1:0]                   col_ff, col_in;
   logic [CW-1:0]                   cur_len_ff, cur_len_in;
   logic [LINES-1:0]                row_vld_ff, row_vld_in;

   logic                            rd_ok_ff, rd_ok_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [mlteb_pkg::W_KEY-1:0]     rd_char_ff, rd_char_in;

   logic [CW-1:0]                   sh_src_ff, sh_src_in;
   logic [CW-1:0]                   sh_cnt_ff, sh_cnt_in;
   logic                            sh_ins_ff, sh_ins_in;
   logic                            wb_pend_ff, wb_pend_in;
   logic [CW-1:0]                   wb_col_ff, wb_col_in;

   logic [mlteb_pkg::W_KEY-1:0]     out_char_ff, out_char_in;
   logic [mlteb_pkg::W_LINE-1:0]    out_line_ff, out_line_in;
   logic [mlteb_pkg::W_COL-1:0]     out_col_ff, out_col_in;
   logic [mlteb_pkg::W_COL-1:0]     out_len_ff, out_len_in;
   logic                            out_fin_ff, out_fin_in;

   logic                            txt_we;
   logic [AW-1:0]                   txt_waddr, txt_raddr;
   logic [mlteb_pkg::W_KEY-1:0]     txt_wdata, txt_rdata;
   logic                            len_we;
   logic [RW-1:0]                   len_raddr;
   logic [CW-1:0]                   len_wdata, len_rdata, len_rd;
   logic [AW-1:0]                   row_base;
   logic [CW-1:0]                   del_pos;
   logic                            printable;
   mlteb_pkg::dp_stat_type          stat_d;

   mlteb_ram #(.WIDTH(mlteb_pkg::W_KEY), .DEPTH(DEPTH)) u_text_ram (
      .clock   (clock),
      .wr_en   (txt_we),
      .wr_addr (txt_waddr),
      .wr_data (txt_wdata),
      .rd_addr (txt_raddr),
      .rd_data (txt_rdata)
   );

   mlteb_ram #(.WIDTH(CW), .DEPTH(LINES)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (row_ff),
      .wr_data (len_wdata),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   assign row_base = AW'(AW'(row_ff) * AW'(CHARS_PER_LINE));
   assign len_rd   = rd_vld_ff ? len_rdata : '0;
   assign printable = (it_key_ff >= mlteb_pkg::PRINT_LO) && (it_key_ff <= mlteb_pkg::PRINT_HI)
                   && (it_key_ff >= {1'b0, lo_ff}) && (it_key_ff <= {1'b0, hi_ff});

   // beat decode against the current editor state
   always_comb begin
      stat_d.act        = mlteb_pkg::ACT_NONE;
      stat_d.pfx_clr    = 1'b0;
      stat_d.shift_busy = (sh_cnt_ff != '0) || wb_pend_ff;
      if (it_cmd_ff == mlteb_pkg::CMD_READ) begin
         stat_d.act = mlteb_pkg::ACT_READ;
      end else if (!done_ff) begin
         if (prefix_ff) begin
            stat_d.pfx_clr = 1'b1;
            unique case (it_key_ff)
               mlteb_pkg::KEY_LEFT:
                  if (col_ff != '0) stat_d.act = mlteb_pkg::ACT_LEFT;
               mlteb_pkg::KEY_RIGHT:
                  if (col_ff < cur_len_ff) stat_d.act = mlteb_pkg::ACT_RIGHT;
               mlteb_pkg::KEY_UP:
                  if (row_ff != '0) stat_d.act = mlteb_pkg::ACT_UP;
               mlteb_pkg::KEY_DOWN:
                  if (row_ff != RW'(LINES - 1)) stat_d.act = mlteb_pkg::ACT_DOWN;
               mlteb_pkg::KEY_HOME: stat_d.act = mlteb_pkg::ACT_HOME;
               mlteb_pkg::KEY_END:  stat_d.act = mlteb_pkg::ACT_END;
               mlteb_pkg::KEY_DEL:
                  if (col_ff < cur_len_ff) stat_d.act = mlteb_pkg::ACT_DELETE;
               default: stat_d.act = mlteb_pkg::ACT_NONE;
            endcase
         end else begin
            priority if (it_key_ff == mlteb_pkg::KEY_PREFIX) begin
               stat_d.act = mlteb_pkg::ACT_PREFIX;
            end else if (it_key_ff == mlteb_pkg::KEY_ENTER) begin
               stat_d.act = mlteb_pkg::ACT_ENTER;
            end else if (it_key_ff == mlteb_pkg::KEY_BACK) begin
               if (col_ff != '0) stat_d.act = mlteb_pkg::ACT_BACK;
            end else if (printable && (cur_len_ff < CW'(CHARS_PER_LINE))) begin
               stat_d.act = mlteb_pkg::ACT_INSERT;
            end else begin
               stat_d.act = mlteb_pkg::ACT_NONE;
            end
         end
      end
   end

   assign stat = stat_d;

   always_comb begin
      it_cmd_in   = it_cmd_ff;
      it_key_in   = it_key_ff;
      it_rl_in    = it_rl_ff;
      it_rc_in    = it_rc_ff;
      prefix_in   = prefix_ff;
      done_in     = done_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      cur_len_in  = cur_len_ff;
      row_vld_in  = row_vld_ff;
      rd_ok_in    = rd_ok_ff;
      rd_char_in  = rd_char_ff;
      sh_src_in   = sh_src_ff;
      sh_cnt_in   = sh_cnt_ff;
      sh_ins_in   = sh_ins_ff;
      wb_pend_in  = 1'b0;
      wb_col_in   = wb_col_ff;
      out_char_in = out_char_ff;
      out_line_in = out_line_ff;
      out_col_in  = out_col_ff;
      out_len_in  = out_len_ff;
      out_fin_in  = out_fin_ff;
      txt_we      = wb_pend_ff;
      txt_waddr   = row_base + AW'(wb_col_ff);
      txt_wdata   = txt_rdata;
      txt_raddr   = row_base + AW'(sh_src_ff);
      len_we      = 1'b0;
      len_wdata   = cur_len_ff;
      len_raddr   = row_ff;
      del_pos     = cmd.del_back ? (col_ff - CW'(1)) : col_ff;

      if (cmd.load) begin
         it_cmd_in  = req_cmd;
         it_key_in  = req_key_byte;
         it_rl_in   = req_read_line;
         it_rc_in   = req_read_col;
         rd_char_in = '0;
      end
      if (cmd.prefix_set) prefix_in = 1'b1;
      if (cmd.prefix_clr) prefix_in = 1'b0;
      if (cmd.done_set)   done_in   = 1'b1;
      if (cmd.col_dec)    col_in    = col_ff - CW'(1);
      if (cmd.col_inc)    col_in    = col_ff + CW'(1);
      if (cmd.col_zero)   col_in    = '0;
      if (cmd.col_end)    col_in    = cur_len_ff;

      if (cmd.rd_issue) begin
         txt_raddr = AW'(AW'(it_rl_ff) * AW'(CHARS_PER_LINE)) + AW'(it_rc_ff);
         len_raddr = RW'(it_rl_ff);
         rd_ok_in  = (int'(it_rl_ff) < LINES) && (int'(it_rc_ff) < CHARS_PER_LINE);
      end
      if (cmd.up_issue)   len_raddr = row_ff - RW'(1);
      if (cmd.down_issue) len_raddr = row_ff + RW'(1);

      if (cmd.rd_capture) begin
         rd_char_in = (rd_ok_ff && (CMPW'(it_rc_ff) < CMPW'(len_rd))) ? txt_rdata : '0;
      end
      if (cmd.up_load) begin
         row_in     = row_ff - RW'(1);
         col_in     = len_rd;
         cur_len_in = len_rd;
      end
      if (cmd.down_load) begin
         row_in     = row_ff + RW'(1);
         col_in     = len_rd;
         cur_len_in = len_rd;
      end

      // delete at del_pos: move columns del_pos+1 .. len-1 one place left
      if (cmd.del_start) begin
         col_in      = del_pos;
         sh_src_in   = del_pos + CW'(1);
         sh_cnt_in   = cur_len_ff - CW'(1) - del_pos;
         sh_ins_in   = 1'b0;
         cur_len_in  = cur_len_ff - CW'(1);
         len_we      = 1'b1;
         len_wdata   = cur_len_ff - CW'(1);
         row_vld_in[row_ff] = 1'b1;
      end
      // insert at col: move columns len-1 down to col one place right
      if (cmd.ins_start) begin
         sh_src_in = cur_len_ff - CW'(1);
         sh_cnt_in = cur_len_ff - col_ff;
         sh_ins_in = 1'b1;
      end
      if (cmd.shift_run && (sh_cnt_ff != '0)) begin
         wb_pend_in = 1'b1;
         wb_col_in  = sh_ins_ff ? (sh_src_ff + CW'(1)) : (sh_src_ff - CW'(1));
         sh_src_in  = sh_ins_ff ? (sh_src_ff - CW'(1)) : (sh_src_ff + CW'(1));
         sh_cnt_in  = sh_cnt_ff - CW'(1);
      end

      if (cmd.put_char) begin
         txt_we     = 1'b1;
         txt_waddr  = row_base + AW'(col_ff);
         txt_wdata  = it_key_ff;
         col_in     = col_ff + CW'(1);
         cur_len_in = cur_len_ff + CW'(1);
         len_we     = 1'b1;
         len_wdata  = cur_len_ff + CW'(1);
         row_vld_in[row_ff] = 1'b1;
      end

      if (cmd.rsp_load) begin
         out_char_in = rd_char_ff;
         out_line_in = mlteb_pkg::W_LINE'(row_ff);
         out_col_in  = mlteb_pkg::W_COL'(col_ff);
         out_len_in  = mlteb_pkg::W_COL'(cur_len_ff);
         out_fin_in  = done_ff;
      end
   end

   assign rd_vld_in = row_vld_ff[len_raddr];

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff      <= mlteb_pkg::LOWEST_CHAR_RST;
         hi_ff      <= mlteb_pkg::HIGHEST_CHAR_RST;
         prefix_ff  <= 1'b0;
         done_ff    <= 1'b0;
         row_ff     <= '0;
         col_ff     <= '0;
         cur_len_ff <= '0;
         row_vld_ff <= '0;
         sh_cnt_ff  <= '0;
         wb_pend_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == mlteb_pkg::CSR_LOWEST_CHAR)) lo_ff <= csr_data;
         if (csr_we && (csr_index == mlteb_pkg::CSR_HIGHEST_CHAR)) hi_ff <= csr_data;
         prefix_ff  <= prefix_in;
         done_ff    <= done_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         cur_len_ff <= cur_len_in;
         row_vld_ff <= row_vld_in;
         sh_cnt_ff  <= sh_cnt_in;
         wb_pend_ff <= wb_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      it_cmd_ff   <= it_cmd_in;
      it_key_ff   <= it_key_in;
      it_rl_ff    <= it_rl_in;
      it_rc_ff    <= it_rc_in;
      rd_ok_ff    <= rd_ok_in;
      rd_vld_ff   <= rd_vld_in;
      rd_char_ff  <= rd_char_in;
      sh_src_ff   <= sh_src_in;
      sh_ins_ff   <= sh_ins_in;
      wb_col_ff   <= wb_col_in;
      out_char_ff <= out_char_in;
      out_line_ff <= out_line_in;
      out_col_ff  <= out_col_in;
      out_len_ff  <= out_len_in;
      out_fin_ff  <= out_fin_in;
   end

   assign rsp_read_char      = out_char_ff;
   assign rsp_cursor_line    = out_line_ff;
   assign rsp_cursor_col     = out_col_ff;
   assign rsp_current_length = out_len_ff;
   assign rsp_finished       = out_fin_ff;

endmodule

`default_nettype wire

@@ rtl/multi_line_text_edit_buffer_unit.sv @@
// Top level of the multi-line text edit buffer.
`default_nettype none

// Takes one beat at a time on req_bus (a key byte or a read of one stored character) and
// returns exactly one result beat on rsp_bus with the read character and the cursor state.
// Cursor moves, prefix, enter and ignored keys go from decode to the result; reads and
// up/down first wait for the registered RAM read; delete and backspace shift the
// characters after the cursor, and an insertion shifts them and then writes the new
// character. The text RAM moves one character a cycle. A new beat is taken while the
// previous result still waits in the output register; its own result then waits until
// that one has gone. The text RAM is not cleared after reset: columns at or beyond a
// line's length read as 0. Registers are written on csr_bus, which is always ready, and
// should only be written while the block is idle.
module multi_line_text_edit_buffer_unit #(
   parameter int LINES          = 6,
   parameter int CHARS_PER_LINE = 20
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mlteb_req_if.sink   req_bus,
   mlteb_rsp_if.source rsp_bus,
   mlteb_csr_if.sink   csr_bus
);

   mlteb_pkg::ctrl_cmd_type ctrl_cmd;
   mlteb_pkg::dp_stat_type  dp_stat;
   logic                    req_ready;
   logic                    rsp_valid;

   mlteb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   mlteb_dp #(.LINES(LINES), .CHARS_PER_LINE(CHARS_PER_LINE)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctrl_cmd),
      .stat               (dp_stat),
      .req_cmd            (req_bus.cmd),
      .req_key_byte       (req_bus.key_byte),
      .req_read_line      (req_bus.read_line),
      .req_read_col       (req_bus.read_col),
      .csr_we             (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .rsp_read_char      (rsp_bus.read_char),
      .rsp_cursor_line    (rsp_bus.cursor_line),
      .rsp_cursor_col     (rsp_bus.cursor_col),
      .rsp_current_length (rsp_bus.current_length),
      .rsp_finished       (rsp_bus.finished)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
   assign csr_bus.ready = 1'b1;

endmodule

`default_nettype wire

@@ rtl/mlteb_checker.sv @@
// Port-level assertions of the line editor, bound to the top level.
`default_nettype none
`include "multi_line_text_edit_buffer_unit_macros.svh"

module mlteb_checker #(
   parameter int CHARS_PER_LINE = 20
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [mlteb_pkg::W_KEY-1:0]        rsp_read_char,
   input wire logic [mlteb_pkg::W_LINE-1:0]       rsp_cursor_line,
   input wire logic [mlteb_pkg::W_COL-1:0]        rsp_cursor_col,
   input wire logic [mlteb_pkg::W_COL-1:0]        rsp_current_length,
   input wire logic                               rsp_finished
);

   logic [1:0] pend_cnt_ff, pend_cnt_in;
   logic       fin_seen_ff, fin_seen_in;
   logic       req_acc, rsp_acc;

   assign req_acc     = req_valid && req_ready;
   assign rsp_acc     = rsp_valid && rsp_ready;
   assign pend_cnt_in = pend_cnt_ff + 2'(req_acc) - 2'(rsp_acc);
   assign fin_seen_in = fin_seen_ff || (rsp_acc && rsp_finished);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= '0;
         fin_seen_ff <= 1'b0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         fin_seen_ff <= fin_seen_in;
      end
   end

   `MLTEB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable({rsp_read_char, rsp_cursor_line, rsp_cursor_col,
      rsp_current_length, rsp_finished}), "result beat changed while stalled")
   `MLTEB_ASSERT_NOW(a_no_orphan_rsp, clock, reset, rsp_valid, pend_cnt_ff != 2'd0,
      "result beat without an outstanding request")
   `MLTEB_ASSERT_NOW(a_finished_sticky, clock, reset, rsp_valid && fin_seen_ff,
      rsp_finished, "finished dropped before reset")
   `MLTEB_ASSERT_NOW(a_cursor_in_line, clock, reset, rsp_valid && (CHARS_PER_LINE < 32),
      (rsp_cursor_col <= rsp_current_length) &&
      (int'(rsp_current_length) <= CHARS_PER_LINE), "cursor beyond line end")

endmodule

bind multi_line_text_edit_buffer_unit mlteb_checker #(.CHARS_PER_LINE(CHARS_PER_LINE)) u_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_read_char      (rsp_bus.read_char),
   .rsp_cursor_line    (rsp_bus.cursor_line),
   .rsp_cursor_col     (rsp_bus.cursor_col),
   .rsp_current_length (rsp_bus.current_length),
   .rsp_finished       (rsp_bus.finished)
);

`default_nettype wire

@@ bench/multi_line_text_edit_buffer_unit_test.sv @@
// Self-checking bench for the line editor buffer: keystrokes and reads against a shadow editor.
`timescale 1ns / 1ps

module multi_line_text_edit_buffer_unit_test;

   localparam int N_LINES    = 6;
   localparam int LINE_CHARS = 20;
   localparam int STALL_LIMIT = 5000;
   localparam logic [mlteb_pkg::W_CSR_IDX-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [mlteb_pkg::W_CSR_IDX-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [mlteb_pkg::W_KEY-1:0]     KEY_ESCAPE  = 8'd27;

   typedef struct packed {
      logic                         cmd;
      logic [mlteb_pkg::W_KEY-1:0]  key;
      logic [mlteb_pkg::W_LINE-1:0] line;
      logic [mlteb_pkg::W_COL-1:0]  col;
   } keystroke_type;

   typedef struct packed {
      logic [mlteb_pkg::W_KEY-1:0]  read_char;
      logic [mlteb_pkg::W_LINE-1:0] cursor_line;
      logic [mlteb_pkg::W_COL-1:0]  cursor_col;
      logic [mlteb_pkg::W_COL-1:0]  current_length;
      logic                         finished;
   } editor_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlteb_req_if req_bus();
   mlteb_rsp_if rsp_bus();
   mlteb_csr_if csr_bus();

   multi_line_text_edit_buffer_unit #(
      .LINES          (N_LINES),
      .CHARS_PER_LINE (LINE_CHARS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // shadow editor
   logic [mlteb_pkg::W_KEY-1:0]  shadow_text [N_LINES][LINE_CHARS];
   int                           shadow_len [N_LINES];
   int                           shadow_row;
   int                           shadow_col;
   logic                         shadow_prefix;
   logic                         shadow_done;
   logic [mlteb_pkg::W_CHAR-1:0] shadow_lo;
   logic [mlteb_pkg::W_CHAR-1:0] shadow_hi;

   keystroke_type   pending_keystrokes[$];
   editor_view_type expected_views[$];
   keystroke_type   offered;
   logic            offer_now;
   editor_view_type want;
   int              idle_pct;
   int              stall_pct;
   int              rsp_hold_left;
   int              errors;
   int              quiet_cycles;

   function automatic void drop_char(int row, int pos);
      int len;
      len = shadow_len[row];
      if (pos >= len) return;
      for (int i = pos; i + 1 < len; i++) shadow_text[row][i] = shadow_text[row][i + 1];
      shadow_text[row][len - 1] = '0;
      shadow_len[row] = len - 1;
   endfunction

   function automatic void place_char(logic [mlteb_pkg::W_KEY-1:0] ch);
      int len;
      len = shadow_len[shadow_row];
      if (len >= LINE_CHARS || shadow_col > len) return;
      for (int i = len; i > shadow_col; i--)
         shadow_text[shadow_row][i] = shadow_text[shadow_row][i - 1];
      shadow_text[shadow_row][shadow_col] = ch;
      shadow_col++;
      shadow_len[shadow_row] = len + 1;
   endfunction

   function automatic void apply_key(logic [mlteb_pkg::W_KEY-1:0] key);
      if (shadow_done) return;
      if (shadow_prefix) begin
         shadow_prefix = 1'b0;
         case (key)
            mlteb_pkg::KEY_LEFT: if (shadow_col > 0) shadow_col--;
            mlteb_pkg::KEY_RIGHT: if (shadow_col < shadow_len[shadow_row]) shadow_col++;
            mlteb_pkg::KEY_UP: begin
               if (shadow_row > 0) begin
                  shadow_row--;
                  shadow_col = shadow_len[shadow_row];
               end
            end
            mlteb_pkg::KEY_DOWN: begin
               if (shadow_row + 1 < N_LINES) begin
                  shadow_row++;
                  shadow_col = shadow_len[shadow_row];
               end
            end
            mlteb_pkg::KEY_HOME: shadow_col = 0;
            mlteb_pkg::KEY_END: shadow_col = shadow_len[shadow_row];
            mlteb_pkg::KEY_DEL: drop_char(shadow_row, shadow_col);
            default: ;
         endcase
      end else if (key == mlteb_pkg::KEY_PREFIX) begin
         shadow_prefix = 1'b1;
      end else if (key == mlteb_pkg::KEY_ENTER) begin
         shadow_done = 1'b1;
      end else if (key == mlteb_pkg::KEY_BACK) begin
         if (shadow_col > 0) begin
            shadow_col--;
            drop_char(shadow_row, shadow_col);
         end
      end else if (key >= mlteb_pkg::PRINT_LO && key <= mlteb_pkg::PRINT_HI &&
                   key >= {1'b0, shadow_lo} && key <= {1'b0, shadow_hi}) begin
         place_char(key);
      end
   endfunction

   function automatic editor_view_type predict_editor_view(keystroke_type b);
      editor_view_type v;
      v.read_char = '0;
      if (b.cmd == mlteb_pkg::CMD_READ) begin
         if (b.line < N_LINES && b.col < LINE_CHARS) v.read_char = shadow_text[b.line][b.col];
      end else begin
         apply_key(b.key);
      end
      v.cursor_line    = mlteb_pkg::W_LINE'(shadow_row);
      v.cursor_col     = mlteb_pkg::W_COL'(shadow_col);
      v.current_length = mlteb_pkg::W_COL'(shadow_len[shadow_row]);
      v.finished       = shadow_done;
      return v;
   endfunction

   function automatic void check_field(string name, logic [mlteb_pkg::W_KEY-1:0] exp_v,
                                       logic [mlteb_pkg::W_KEY-1:0] act_v);
      if (act_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_views.push_back(predict_editor_view(offered));
         if (!req_bus.valid || req_bus.ready) begin
            offer_now = pending_keystrokes.size() != 0 && $urandom_range(99) >= idle_pct;
            if (offer_now) begin
               offered = pending_keystrokes.pop_front();
               req_bus.cmd       <= offered.cmd;
               req_bus.key_byte  <= offered.key;
               req_bus.read_line <= offered.line;
               req_bus.read_col  <= offered.col;
            end
            req_bus.valid <= offer_now;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_views.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, got char %0d line %0d col %0d",
                        $time, rsp_bus.read_char, rsp_bus.cursor_line, rsp_bus.cursor_col);
            end else begin
               want = expected_views.pop_front();
               check_field("read_char", want.read_char, rsp_bus.read_char);
               check_field("cursor_line", 8'(want.cursor_line), 8'(rsp_bus.cursor_line));
               check_field("cursor_col", 8'(want.cursor_col), 8'(rsp_bus.cursor_col));
               check_field("current_length", 8'(want.current_length),
                           8'(rsp_bus.current_length));
               check_field("finished", 8'(want.finished), 8'(rsp_bus.finished));
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= $urandom_range(99) >= stall_pct;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void push_key(logic [mlteb_pkg::W_KEY-1:0] k);
      keystroke_type b;
      b.cmd  = mlteb_pkg::CMD_KEY;
      b.key  = k;
      b.line = mlteb_pkg::W_LINE'($urandom);
      b.col  = mlteb_pkg::W_COL'($urandom);
      pending_keystrokes.push_back(b);
   endfunction

   function automatic void push_read(int l, int c);
      keystroke_type b;
      b.cmd  = mlteb_pkg::CMD_READ;
      b.key  = mlteb_pkg::W_KEY'($urandom);
      b.line = mlteb_pkg::W_LINE'(l);
      b.col  = mlteb_pkg::W_COL'(c);
      pending_keystrokes.push_back(b);
   endfunction

   function automatic void push_ext(logic [mlteb_pkg::W_KEY-1:0] code);
      push_key(mlteb_pkg::KEY_PREFIX);
      push_key(code);
   endfunction

   function automatic void queue_random_edits(int n);
      int                          made;
      int                          pick;
      int                          lo_eff;
      int                          hi_eff;
      logic [mlteb_pkg::W_KEY-1:0] k;
      made = 0;
      while (made < n) begin
         pick   = $urandom_range(99);
         lo_eff = (shadow_lo < mlteb_pkg::PRINT_LO) ? mlteb_pkg::PRINT_LO : shadow_lo;
         hi_eff = (shadow_hi > mlteb_pkg::PRINT_HI) ? mlteb_pkg::PRINT_HI : shadow_hi;
         if (pick < 35) begin
            if (lo_eff <= hi_eff && $urandom_range(3) != 0)
               k = mlteb_pkg::W_KEY'($urandom_range(hi_eff, lo_eff));
            else
               k = mlteb_pkg::W_KEY'($urandom_range(mlteb_pkg::PRINT_HI, mlteb_pkg::PRINT_LO));
            push_key(k);
            made++;
         end else if (pick < 60) begin
            case ($urandom_range(9))
               0: k = mlteb_pkg::KEY_LEFT;
               1: k = mlteb_pkg::KEY_RIGHT;
               2: k = mlteb_pkg::KEY_UP;
               3: k = mlteb_pkg::KEY_DOWN;
               4: k = mlteb_pkg::KEY_HOME;
               5: k = mlteb_pkg::KEY_END;
               6, 7: k = mlteb_pkg::KEY_DEL;
               8: k = mlteb_pkg::W_KEY'($urandom);
               default: k = mlteb_pkg::KEY_PREFIX;
            endcase
            push_key(mlteb_pkg::KEY_PREFIX);
            if ($urandom_range(9) == 0) begin
               push_read($urandom_range(N_LINES - 1), $urandom_range(LINE_CHARS - 1));
               made++;
            end
            push_key(k);
            made += 2;
         end else if (pick < 70) begin
            push_key(mlteb_pkg::KEY_BACK);
            made++;
         end else if (pick < 90) begin
            if ($urandom_range(4) == 0)
               push_read($urandom_range(7), $urandom_range(31));
            else
               push_read($urandom_range(N_LINES - 1), $urandom_range(LINE_CHARS - 1));
            made++;
         end else begin
            k = mlteb_pkg::W_KEY'($urandom);
            if (k == mlteb_pkg::KEY_ENTER) k = KEY_ESCAPE;
            push_key(k);
            made++;
         end
      end
   endfunction

   task automatic write_reg(logic [mlteb_pkg::W_CSR_IDX-1:0] idx,
                            logic [mlteb_pkg::W_CHAR-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == mlteb_pkg::CSR_LOWEST_CHAR) shadow_lo = val;
      else if (idx == mlteb_pkg::CSR_HIGHEST_CHAR) shadow_hi = val;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_keystrokes.size() != 0 || req_bus.valid || expected_views.size() != 0);
   endtask

   initial begin
      int lo_set [6];
      int hi_set [6];
      lo_set = '{32, 126, 32, 0, 126, 65};
      hi_set = '{126, 126, 32, 127, 32, 90};
      req_bus.valid     = 1'b0;
      req_bus.cmd       = mlteb_pkg::CMD_KEY;
      req_bus.key_byte  = '0;
      req_bus.read_line = '0;
      req_bus.read_col  = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      for (int r = 0; r < N_LINES; r++) begin
         shadow_len[r] = 0;
         for (int c = 0; c < LINE_CHARS; c++) shadow_text[r][c] = '0;
      end
      shadow_row    = 0;
      shadow_col    = 0;
      shadow_prefix = 1'b0;
      shadow_done   = 1'b0;
      shadow_lo     = mlteb_pkg::LOWEST_CHAR_RST;
      shadow_hi     = mlteb_pkg::HIGHEST_CHAR_RST;
      idle_pct      = 0;
      stall_pct     = 0;
      rsp_hold_left = 0;
      errors        = 0;
      quiet_cycles  = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: range edges, bounds, every extended code, prefix held across a read
      push_read(7, 31);
      push_read(0, 20);
      push_key(8'd47);
      push_key(8'd48);
      push_key(8'd122);
      push_key(8'd123);
      push_key(8'd255);
      push_ext(mlteb_pkg::KEY_LEFT);
      push_ext(mlteb_pkg::KEY_DEL);
      push_ext(mlteb_pkg::KEY_DEL);
      push_ext(mlteb_pkg::KEY_HOME);
      push_ext(mlteb_pkg::KEY_LEFT);
      push_key(mlteb_pkg::KEY_BACK);
      push_read(0, 0);
      push_ext(mlteb_pkg::KEY_END);
      push_ext(mlteb_pkg::KEY_UP);
      push_ext(mlteb_pkg::KEY_DOWN);
      push_ext(mlteb_pkg::KEY_PREFIX);
      push_key(mlteb_pkg::KEY_PREFIX);
      push_read(0, 0);
      push_key(mlteb_pkg::KEY_RIGHT);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_reg(mlteb_pkg::CSR_LOWEST_CHAR, mlteb_pkg::W_CHAR'(lo_set[p]));
         write_reg(mlteb_pkg::CSR_HIGHEST_CHAR, mlteb_pkg::W_CHAR'(hi_set[p]));
         if (p == 2) begin
            write_reg(CSR_SPARE_A, mlteb_pkg::W_CHAR'($urandom));
            write_reg(CSR_SPARE_B, mlteb_pkg::W_CHAR'($urandom));
         end
         @(negedge clock);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         if (p == 0) rsp_hold_left = 300;
         queue_random_edits(165);
         if (p == 5) begin
            // second enter in case the first lands as an extended code
            push_key(mlteb_pkg::KEY_ENTER);
            push_key(mlteb_pkg::KEY_ENTER);
            queue_random_edits(15);
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
